### hw/rtl/hex_text_image_parser_core_defines.svh
// Assertion macros shared by the hex-text image parser RTL.
// Depends on nothing; included by the top level only.
`ifndef HEX_TEXT_IMAGE_PARSER_CORE_DEFINES_SVH
`define HEX_TEXT_IMAGE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HEXP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hexp same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HEXP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hexp next-cycle check failed");

`endif

### hw/rtl/hexp_pkg.sv
// Types, constants and the hex digit decoder for the hex-text image parser.
// No dependencies; imported by every module of the block.
package hexp_pkg;

   localparam int MAX_SEGMENTS = 8;
   localparam logic [3:0] MAX_SEGMENTS_W = 4'(MAX_SEGMENTS);
   localparam logic [15:0] SEGMENT_CAPACITY = 16'(65535);

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_AT = 8'h40;
   localparam logic [7:0] CHAR_Q  = 8'h71;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ADDR = 2'd1,
      PH_DATA = 2'd2,
      PH_SEP  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      K_DATA    = 3'd0,
      K_OPEN    = 3'd1,
      K_END     = 3'd2,
      K_BAD     = 3'd3,
      K_NOSEG   = 3'd4,
      K_TOOMANY = 3'd5,
      K_FULL    = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] address;
      logic [7:0]  data_byte;
      logic [2:0]  segment_number;
      logic [15:0] closed_length;
      logic        closed_valid;
   } result_type;

   typedef struct packed {
      phase_type phase;
      logic      seg_open;
      logic      finished;
   } status_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type r;
      r.is_hex = 1'b1;
      r.value  = c[3:0];
      if (c >= 8'h30 && c <= 8'h39) begin
         r.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r.value = c[3:0] + 4'd9;
      end else begin
         r.is_hex = 1'b0;
         r.value  = 4'd0;
      end
      return r;
   endfunction

endpackage

### hw/rtl/hex_text_image_parser_core.sv
// Hex-text firmware image parser.
// Input channel (req_): one character per transaction, req_last_char marks the
// final character of an image; the parser returns to its reset state after it.
// Result channel (rsp_): zero or one result per character: data byte with its
// address, segment open (with the length of the segment it closes), end,
// or an error kind.
// A result follows its character through the input register, then through
// the parse logic into the result register, where it is presented.
// Throughput: one character per cycle while the receiver does not stall; the
// parse state updates on each fired character, so consecutive characters
// flow without gaps.
// When the receiver stalls, the result register holds its transaction; the
// input register still takes one more character, and req_stall rises while
// that character waits behind the held result register.
// Reset (synchronous) empties both registers and clears all parse state.
// Depends on hexp_pkg, hexp_in_stage, hexp_parser, hexp_out_stage and the
// assertion macros header.
`include "hex_text_image_parser_core_defines.svh"

module hex_text_image_parser_core
   import hexp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_kind,
   output logic [15:0] rsp_address,
   output logic [7:0]  rsp_data_byte,
   output logic [2:0]  rsp_segment_number,
   output logic [15:0] rsp_closed_length,
   output logic        rsp_closed_valid
);

   logic       out_ready;
   logic       fire;
   logic [7:0] char_q;
   logic       last_q;
   logic       res_valid;
   result_type res;
   result_type rsp_res;
   status_type status;

   hexp_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_char_in  (req_char_in),
      .req_last_char(req_last_char),
      .out_ready    (out_ready),
      .fire         (fire),
      .char_q       (char_q),
      .last_q       (last_q)
   );

   hexp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .char_in  (char_q),
      .last_char(last_q),
      .res_valid(res_valid),
      .res      (res),
      .status   (status)
   );

   hexp_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .res_valid(res_valid),
      .res      (res),
      .rsp_stall(rsp_stall),
      .out_ready(out_ready),
      .rsp_valid(rsp_valid),
      .rsp_res  (rsp_res)
   );

   assign rsp_result_kind    = rsp_res.kind;
   assign rsp_address        = rsp_res.address;
   assign rsp_data_byte      = rsp_res.data_byte;
   assign rsp_segment_number = rsp_res.segment_number;
   assign rsp_closed_length  = rsp_res.closed_length;
   assign rsp_closed_valid   = rsp_res.closed_valid;

   `HEXP_ASSERT_IMPL(a_stall_needs_item, clock, reset, req_stall, fire == 1'b0)
   `HEXP_ASSERT_IMPL(a_closed_kind, clock, reset, rsp_valid && rsp_res.closed_valid,
      rsp_res.kind == K_OPEN || rsp_res.kind == K_END)
   `HEXP_ASSERT_NEXT(a_last_resets, clock, reset, fire && last_q,
      status.phase == PH_IDLE && !status.seg_open && !status.finished)

endmodule

### hw/rtl/hexp_in_stage.sv
// Input register of the hex-text image parser: one character and its last flag.
// Depends on hexp_pkg.
module hexp_in_stage
   import hexp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_last_char,
   input  logic       out_ready,
   output logic       fire,
   output logic [7:0] char_q,
   output logic       last_q
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff;
   logic       last_ff;
   logic       accept;

   // Hold the character only while the result register cannot take it.
   assign req_stall = valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;
   assign fire      = valid_ff && out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req_char_in;
         last_ff <= req_last_char;
      end
   end

   assign char_q = char_ff;
   assign last_q = last_ff;

endmodule

### hw/rtl/hexp_parser.sv
// Parse state and per-character token logic of the hex-text image parser.
// Depends on hexp_pkg (phase and result types, hex_decode, limits).
module hexp_parser
   import hexp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] char_in,
   input  logic       last_char,
   output logic       res_valid,
   output result_type res,
   output status_type status
);

   phase_type     phase_ff, phase_in;
   logic [1:0]    digit_count_ff, digit_count_in;
   logic [15:0]   acc_ff, acc_in;
   logic [15:0]   start_ff, start_in;
   logic [15:0]   bcount_ff, bcount_in;
   logic [2:0]    seg_idx_ff, seg_idx_in;
   logic          seg_open_ff, seg_open_in;
   logic          finished_ff, finished_in;

   hex_digit_type hd;
   logic          active;
   logic          too_many;
   logic [15:0]   acc_shift;
   logic [7:0]    byte_val;

   assign hd        = hex_decode(char_in);
   assign active    = fire && !finished_ff;
   assign too_many  = seg_open_ff && (({1'b0, seg_idx_ff} + 4'd1) >= MAX_SEGMENTS_W);
   assign acc_shift = {acc_ff[11:0], hd.value};
   assign byte_val  = {acc_ff[3:0], hd.value};

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (active) begin
         unique case (phase_ff)
            PH_ADDR: begin
               if (!hd.is_hex || digit_count_ff == 2'd3) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_DATA: phase_in = hd.is_hex ? PH_SEP : PH_IDLE;
            PH_SEP:  phase_in = PH_IDLE;
            PH_IDLE: begin
               if (char_in == CHAR_AT) begin
                  phase_in = PH_ADDR;
               end else if (hd.is_hex) begin
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         endcase
      end
      if (fire && last_char) begin
         phase_in = PH_IDLE;
      end
   end

   // Datapath updates and result
   always_comb begin
      digit_count_in = digit_count_ff;
      acc_in         = acc_ff;
      start_in       = start_ff;
      bcount_in      = bcount_ff;
      seg_idx_in     = seg_idx_ff;
      seg_open_in    = seg_open_ff;
      finished_in    = finished_ff;
      res_valid      = 1'b0;
      res            = '0;
      if (active) begin
         unique case (phase_ff)
            PH_ADDR: begin
               if (!hd.is_hex) begin
                  res_valid = 1'b1;
                  res.kind  = K_BAD;
               end else begin
                  acc_in = acc_shift;
                  if (digit_count_ff != 2'd3) begin
                     digit_count_in = digit_count_ff + 2'd1;
                  end else begin
                     digit_count_in = 2'd0;
                     res_valid      = 1'b1;
                     if (too_many) begin
                        res.kind = K_TOOMANY;
                     end else begin
                        res.kind    = K_OPEN;
                        res.address = acc_shift;
                        if (seg_open_ff) begin
                           res.closed_length = bcount_ff;
                           res.closed_valid  = 1'b1;
                           seg_idx_in        = seg_idx_ff + 3'd1;
                        end else begin
                           seg_idx_in = 3'd0;
                        end
                        seg_open_in = 1'b1;
                        start_in    = acc_shift;
                        bcount_in   = 16'd0;
                     end
                  end
               end
            end
            PH_DATA: begin
               res_valid = 1'b1;
               if (!hd.is_hex) begin
                  res.kind = K_BAD;
               end else if (!seg_open_ff) begin
                  res.kind      = K_NOSEG;
                  res.data_byte = byte_val;
               end else if (bcount_ff >= SEGMENT_CAPACITY) begin
                  res.kind      = K_FULL;
                  res.data_byte = byte_val;
               end else begin
                  res.kind      = K_DATA;
                  res.data_byte = byte_val;
                  res.address   = start_ff + bcount_ff;
                  bcount_in     = bcount_ff + 16'd1;
               end
            end
            PH_SEP: begin
               res_valid = 1'b0;
            end
            PH_IDLE: begin
               if (char_in == CHAR_CR || char_in == CHAR_LF) begin
                  res_valid = 1'b0;
               end else if (char_in == CHAR_AT) begin
                  digit_count_in = 2'd0;
                  acc_in         = 16'd0;
               end else if (hd.is_hex) begin
                  acc_in = {12'd0, hd.value};
               end else if (char_in == CHAR_Q) begin
                  finished_in = 1'b1;
                  res_valid   = 1'b1;
                  res.kind    = K_END;
                  if (seg_open_ff) begin
                     res.closed_length = bcount_ff;
                     res.closed_valid  = 1'b1;
                  end
               end else begin
                  res_valid = 1'b1;
                  res.kind  = K_BAD;
               end
            end
         endcase
      end
      res.segment_number = seg_idx_in;
      // Drop everything after the final character of an image.
      if (fire && last_char) begin
         digit_count_in = 2'd0;
         acc_in         = 16'd0;
         start_in       = 16'd0;
         bcount_in      = 16'd0;
         seg_idx_in     = 3'd0;
         seg_open_in    = 1'b0;
         finished_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         digit_count_ff <= 2'd0;
         acc_ff         <= 16'd0;
         start_ff       <= 16'd0;
         bcount_ff      <= 16'd0;
         seg_idx_ff     <= 3'd0;
         seg_open_ff    <= 1'b0;
         finished_ff    <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         digit_count_ff <= digit_count_in;
         acc_ff         <= acc_in;
         start_ff       <= start_in;
         bcount_ff      <= bcount_in;
         seg_idx_ff     <= seg_idx_in;
         seg_open_ff    <= seg_open_in;
         finished_ff    <= finished_in;
      end
   end

   assign status.phase    = phase_ff;
   assign status.seg_open = seg_open_ff;
   assign status.finished = finished_ff;

endmodule

### hw/rtl/hexp_out_stage.sv
// Result register of the hex-text image parser; holds a transaction while stalled.
// Depends on hexp_pkg (result_type).
module hexp_out_stage
   import hexp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic       res_valid,
   input  result_type res,
   input  logic       rsp_stall,
   output logic       out_ready,
   output logic       rsp_valid,
   output result_type rsp_res
);

   logic       valid_ff, valid_in;
   result_type res_ff;
   logic       load;

   assign out_ready = !valid_ff || !rsp_stall;
   assign load      = fire && res_valid;

   always_comb begin
      valid_in = valid_ff;
      if (out_ready) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

endmodule

### tb/sv/hexp_result_tracker_pkg.sv
// Scoreboard for the hex-text image parser: predicts the result of every
// accepted character and checks the results the block hands out.
// Depends on hexp_pkg for the result struct, the kind and phase enums and the constants.
package hexp_result_tracker_pkg;
   import hexp_pkg::*;

   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   class image_result_tracker;
      result_type  pending_results[$];
      int          errors;
      phase_type   phase;
      logic [2:0]  digits;
      logic [15:0] accum;
      logic [15:0] seg_start;
      logic [15:0] seg_bytes;
      logic [2:0]  seg_index;
      logic        seg_open;
      logic        finished;

      function new();
         errors = 0;
         clear_state();
      endfunction

      function void clear_state();
         phase     = PH_IDLE;
         digits    = '0;
         accum     = '0;
         seg_start = '0;
         seg_bytes = '0;
         seg_index = '0;
         seg_open  = 1'b0;
         finished  = 1'b0;
      endfunction

      // Advance the parse state by one accepted character, queue its result if any.
      function void note_char(input logic [7:0] c, input logic last);
         result_type r;
         logic       produce;
         logic       is_hex;
         logic [3:0] nib;
         r       = '0;
         produce = 1'b0;
         is_hex  = 1'b1;
         nib     = '0;
         if (c >= CH_ZERO && c <= CH_NINE) begin
            nib = 4'(c - CH_ZERO);
         end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            nib = 4'(c - CH_LOWER_A + 8'd10);
         end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            nib = 4'(c - CH_UPPER_A + 8'd10);
         end else begin
            is_hex = 1'b0;
         end

         if (!finished) begin
            case (phase)
               PH_ADDR: begin
                  if (!is_hex) begin
                     phase   = PH_IDLE;
                     r.kind  = K_BAD;
                     produce = 1'b1;
                  end else begin
                     accum  = {accum[11:0], nib};
                     digits = digits + 3'd1;
                     if (digits == 3'd4) begin
                        phase   = PH_IDLE;
                        digits  = '0;
                        produce = 1'b1;
                        if (seg_open && int'(seg_index) + 1 >= MAX_SEGMENTS) begin
                           r.kind = K_TOOMANY;
                        end else begin
                           r.kind = K_OPEN;
                           if (seg_open) begin
                              r.closed_length = seg_bytes;
                              r.closed_valid  = 1'b1;
                              seg_index       = seg_index + 3'd1;
                           end else begin
                              seg_open  = 1'b1;
                              seg_index = '0;
                           end
                           seg_start = accum;
                           seg_bytes = '0;
                           r.address = accum;
                        end
                     end
                  end
               end
               PH_DATA: begin
                  produce = 1'b1;
                  if (!is_hex) begin
                     phase  = PH_IDLE;
                     r.kind = K_BAD;
                  end else begin
                     phase       = PH_SEP;
                     r.data_byte = {accum[3:0], nib};
                     if (!seg_open) begin
                        r.kind = K_NOSEG;
                     end else if (seg_bytes >= SEGMENT_CAPACITY) begin
                        r.kind = K_FULL;
                     end else begin
                        r.kind    = K_DATA;
                        r.address = seg_start + seg_bytes;
                        seg_bytes = seg_bytes + 16'd1;
                     end
                  end
               end
               // separator: drop whatever it is
               PH_SEP: phase = PH_IDLE;
               default: begin
                  if (c == CHAR_AT) begin
                     phase  = PH_ADDR;
                     digits = '0;
                     accum  = '0;
                  end else if (is_hex) begin
                     phase = PH_DATA;
                     accum = {12'd0, nib};
                  end else if (c == CHAR_Q) begin
                     finished        = 1'b1;
                     r.kind          = K_END;
                     r.closed_length = seg_open ? seg_bytes : 16'd0;
                     r.closed_valid  = seg_open;
                     produce         = 1'b1;
                  end else if (c != CHAR_CR && c != CHAR_LF) begin
                     r.kind  = K_BAD;
                     produce = 1'b1;
                  end
               end
            endcase
         end

         if (produce) begin
            r.segment_number = seg_index;
            pending_results.push_back(r);
         end
         if (last) begin
            clear_state();
         end
      endfunction

      function void check_result(input result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction: kind %0d address %h",
                   got.kind, got.address);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got.kind !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
            errors++;
         end
         if (got.address !== want.address) begin
            $error("address: expected %h, got %h", want.address, got.address);
            errors++;
         end
         if (got.data_byte !== want.data_byte) begin
            $error("data_byte: expected %h, got %h", want.data_byte, got.data_byte);
            errors++;
         end
         if (got.segment_number !== want.segment_number) begin
            $error("segment_number: expected %0d, got %0d",
                   want.segment_number, got.segment_number);
            errors++;
         end
         if (got.closed_length !== want.closed_length) begin
            $error("closed_length: expected %0d, got %0d",
                   want.closed_length, got.closed_length);
            errors++;
         end
         if (got.closed_valid !== want.closed_valid) begin
            $error("closed_valid: expected %b, got %b", want.closed_valid, got.closed_valid);
            errors++;
         end
      endfunction
   endclass

endpackage

### tb/sv/tb_hex_text_image_parser_core.sv
// Top-level testbench for hex_text_image_parser_core: directed tokens, random
// images with noise, a full-rate burst and back-pressure on both channels.
// Depends on hexp_pkg and hexp_result_tracker_pkg.
module tb_hex_text_image_parser_core;
   import hexp_pkg::*;
   import hexp_result_tracker_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 120;
   localparam int RANDOM_CHARS = 450;
   localparam int DRAIN_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in = '0;
   logic        req_last_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_result_kind;
   logic [15:0] rsp_address;
   logic [7:0]  rsp_data_byte;
   logic [2:0]  rsp_segment_number;
   logic [15:0] rsp_closed_length;
   logic        rsp_closed_valid;

   image_result_tracker tracker;
   bit         send_fast = 1'b0;
   bit         take_fast = 1'b0;
   bit         hold_request = 1'b0;
   int         send_quiet = 0;
   int         take_quiet = 0;
   int         random_chars = 0;
   int         cycle_count = 0;
   logic [7:0] image_text[$];

   hex_text_image_parser_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_in        (req_char_in),
      .req_last_char      (req_last_char),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_address        (rsp_address),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_segment_number (rsp_segment_number),
      .rsp_closed_length  (rsp_closed_length),
      .rsp_closed_valid   (rsp_closed_valid)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Wait length for one transaction; now and then a quiet stretch with no waits.
   function automatic int pick_wait(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         quiet = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 9);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) begin
         return CH_ZERO + 8'(v);
      end
      if ($urandom_range(0, 1) == 0) begin
         return CH_LOWER_A + 8'(v - 4'd10);
      end
      return CH_UPPER_A + 8'(v - 4'd10);
   endfunction

   // Append one character to the image, now and then replaced by a random byte.
   function automatic void put(input logic [7:0] c);
      if ($urandom_range(0, 39) == 0) begin
         image_text.push_back(8'($urandom_range(0, 255)));
      end else begin
         image_text.push_back(c);
      end
   endfunction

   // Entered and left at a falling edge; valid stays high when the next char follows at once.
   task automatic send_char(input logic [7:0] c, input logic last);
      int gap;
      gap = send_fast ? 0 : pick_wait(send_quiet);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_in   <= c;
      req_last_char <= last;
      do @(posedge clock); while (req_stall);
      tracker.note_char(c, last);
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input logic last);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], last && (i == s.len() - 1));
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (tracker.pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic send_random_image();
      int          nseg;
      int          nbytes;
      logic [15:0] start;
      image_text.delete();
      if ($urandom_range(0, 5) == 0) begin
         put(hex_char(4'($urandom)));
         put(hex_char(4'($urandom)));
         put(CH_SPACE);
      end
      nseg = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 10) : $urandom_range(1, 4);
      for (int s = 0; s < nseg; s++) begin
         start = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(16'hFFF8, 16'hFFFF))
                                              : 16'($urandom);
         put(CHAR_AT);
         for (int d = 3; d >= 0; d--) begin
            put(hex_char(start[4*d +: 4]));
         end
         put(CHAR_CR);
         put(CHAR_LF);
         nbytes = (nseg >= 8) ? $urandom_range(0, 1) : $urandom_range(0, 6);
         for (int b = 0; b < nbytes; b++) begin
            put(hex_char(4'($urandom)));
            put(hex_char(4'($urandom)));
            put(($urandom_range(0, 7) == 0) ? 8'($urandom) : CH_SPACE);
            if (b % 4 == 3) begin
               put(CHAR_CR);
               put(CHAR_LF);
            end
         end
      end
      if ($urandom_range(0, 9) != 0) begin
         put(CHAR_Q);
      end
      repeat ($urandom_range(0, 2)) put(8'($urandom));
      foreach (image_text[i]) begin
         send_char(image_text[i], i == image_text.size() - 1);
      end
      random_chars += image_text.size();
   endtask

   initial begin : result_sink
      int         n;
      result_type got;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            n = HOLD_CYCLES;
            hold_request = 1'b0;
         end else if (take_fast) begin
            n = 0;
         end else begin
            n = pick_wait(take_quiet);
         end
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.kind           = kind_type'(rsp_result_kind);
         got.address        = rsp_address;
         got.data_byte      = rsp_data_byte;
         got.segment_number = rsp_segment_number;
         got.closed_length  = rsp_closed_length;
         got.closed_valid   = rsp_closed_valid;
         tracker.check_result(got);
      end
   end

   initial begin : char_source
      tracker = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // data before any segment, then a segment at the top of the address space
      send_text("12 ", 1'b0);
      send_text("@ffFF", 1'b0);
      send_char(CHAR_CR, 1'b0);
      send_char(CHAR_LF, 1'b0);
      send_text("A0 ", 1'b0);
      // address wraps to zero; NUL as separator
      send_text("9e", 1'b0);
      send_char(8'h00, 1'b0);
      // short address, lone data digit, unknown token
      send_text("@1g", 1'b0);
      send_text("5", 1'b0);
      send_char(8'hFF, 1'b0);
      send_text("z", 1'b0);
      send_char(CHAR_Q, 1'b0);
      // ignored after end; last char restarts the image
      send_text("x", 1'b1);
      send_char(CHAR_Q, 1'b1);
      wait_drained();

      while (random_chars < RANDOM_CHARS / 2) send_random_image();

      // hold the result side while the sender keeps pushing bad chars
      hold_request = 1'b1;
      send_fast    = 1'b1;
      repeat (30) send_char("#", 1'b0);
      send_fast = 1'b0;
      wait_drained();

      while (random_chars < RANDOM_CHARS) send_random_image();

      // run one short image at full rate on both sides
      send_fast = 1'b1;
      take_fast = 1'b1;
      send_text("@8000", 1'b0);
      for (int i = 0; i < 16; i++) begin
         send_char(hex_char(4'($urandom)), 1'b0);
         send_char(hex_char(4'($urandom)), 1'b0);
         send_char(($urandom_range(0, 15) == 0) ? 8'($urandom) : CH_SPACE, 1'b0);
      end
      send_text("@0100", 1'b0);
      send_text("A5 q", 1'b1);
      send_fast = 1'b0;
      take_fast = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (tracker.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
